// ===== hdl/skt_pkg.sv =====
// shared types and constants for the sorted key table
// used by skt_ctrl, sorted_key_table and the testbench; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 16;
    localparam int PAY_W    = 32;
    localparam int STAT_W   = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int ENTRY_W  = KEY_W + PAY_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_LOOKUP = 2'd2
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   position;
        logic [PAY_W-1:0]   found_payload;
        logic [COUNT_W-1:0] entry_count;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/skt_ram.sv =====
// generic simple dual-port ram: one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module skt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/skt_ctrl.sv =====
// sequencer of the sorted key table: linear search, then one-entry-a-cycle shift
// depends on skt_pkg and skt_ram
`timescale 1ns / 1ps
`default_nettype none

module skt_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_req_valid,
    output logic                              o_req_ready,
    input  wire logic [skt_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [skt_pkg::KEY_W-1:0]    i_key,
    input  wire logic [skt_pkg::PAY_W-1:0]    i_payload,
    input  wire logic                         i_res_free,
    output logic                              o_res_valid,
    output skt_pkg::t_result                  o_result
);

    localparam int CW = skt_pkg::CNT_W;
    localparam int AW = skt_pkg::ADDR_W;

    skt_pkg::t_state            r_state, n_state;
    logic [CW-1:0]              r_fill, n_fill;
    logic [skt_pkg::FUNC_W-1:0] r_func, n_func;
    logic [skt_pkg::KEY_W-1:0]  r_key, n_key;
    logic [skt_pkg::PAY_W-1:0]  r_pay, n_pay;
    logic [CW-1:0]              r_ptr, n_ptr;
    logic                       r_rd_vld, n_rd_vld;
    logic [CW-1:0]              r_rd_idx, n_rd_idx;
    logic [CW-1:0]              r_pos, n_pos;
    logic                       r_up, n_up;
    logic [CW-1:0]              r_src, n_src;
    logic [CW-1:0]              r_left, n_left;
    logic                       r_mv_vld, n_mv_vld;
    logic [CW-1:0]              r_mv_dst, n_mv_dst;
    logic [skt_pkg::STAT_W-1:0] r_status, n_status;
    logic [skt_pkg::PAY_W-1:0]  r_fpay, n_fpay;

    logic                       ram_we, ram_re;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [skt_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
    skt_pkg::t_entry            rd_entry;

    logic                       stop;
    logic                       hit;
    logic [CW-1:0]              stop_pos;

    skt_ram #(
        .DEPTH (skt_pkg::CAPACITY),
        .WIDTH (skt_pkg::ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = skt_pkg::t_entry'(ram_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= skt_pkg::ST_IDLE;
            r_fill   <= '0;
            r_rd_vld <= 1'b0;
            r_mv_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_rd_vld <= n_rd_vld;
            r_mv_vld <= n_mv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_key    <= n_key;
        r_pay    <= n_pay;
        r_ptr    <= n_ptr;
        r_rd_idx <= n_rd_idx;
        r_pos    <= n_pos;
        r_up     <= n_up;
        r_src    <= n_src;
        r_left   <= n_left;
        r_mv_dst <= n_mv_dst;
        r_status <= n_status;
        r_fpay   <= n_fpay;
    end

    // search: compare the word read last cycle while the next read goes out
    always_comb begin
        stop     = 1'b0;
        hit      = 1'b0;
        stop_pos = r_fill;
        if (r_rd_vld && (r_key <= rd_entry.key)) begin
            stop     = 1'b1;
            hit      = (r_key == rd_entry.key);
            stop_pos = r_rd_idx;
        end else if (r_ptr == r_fill) begin
            stop = 1'b1;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_func   = r_func;
        n_key    = r_key;
        n_pay    = r_pay;
        n_ptr    = r_ptr;
        n_rd_vld = r_rd_vld;
        n_rd_idx = r_rd_idx;
        n_pos    = r_pos;
        n_up     = r_up;
        n_src    = r_src;
        n_left   = r_left;
        n_mv_vld = r_mv_vld;
        n_mv_dst = r_mv_dst;
        n_status = r_status;
        n_fpay   = r_fpay;

        ram_we    = 1'b0;
        ram_waddr = r_mv_dst[AW-1:0];
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_ptr[AW-1:0];

        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_result.status        = r_status;
        o_result.position      = skt_pkg::POS_W'(r_pos);
        o_result.found_payload = r_fpay;
        o_result.entry_count   = skt_pkg::COUNT_W'(r_fill);

        case (r_state)
            skt_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_func   = i_func;
                    n_key    = i_key;
                    n_pay    = i_payload;
                    n_ptr    = '0;
                    n_rd_vld = 1'b0;
                    n_pos    = '0;
                    n_fpay   = '0;
                    n_status = skt_pkg::STAT_NOT_FOUND;
                    case (i_func)
                        skt_pkg::FN_INSERT: begin
                            if (r_fill >= CW'(skt_pkg::CAPACITY)) begin
                                n_status = skt_pkg::STAT_FULL;
                                n_state  = skt_pkg::ST_RESP;
                            end else begin
                                n_state = skt_pkg::ST_SEARCH;
                            end
                        end
                        skt_pkg::FN_REMOVE, skt_pkg::FN_LOOKUP: begin
                            n_state = skt_pkg::ST_SEARCH;
                        end
                        default: begin
                            n_state = skt_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            skt_pkg::ST_SEARCH: begin
                if (stop) begin
                    n_rd_vld = 1'b0;
                    n_mv_vld = 1'b0;
                    case (r_func)
                        skt_pkg::FN_INSERT: begin
                            n_status = skt_pkg::STAT_DONE;
                            n_pos    = stop_pos;
                            n_up     = 1'b1;
                            n_src    = r_fill - CW'(1);
                            n_left   = r_fill - stop_pos;
                            n_state  = skt_pkg::ST_SHIFT;
                        end
                        skt_pkg::FN_REMOVE: begin
                            if (hit) begin
                                n_status = skt_pkg::STAT_DONE;
                                n_pos    = stop_pos;
                                n_fpay   = rd_entry.payload;
                                n_up     = 1'b0;
                                n_src    = stop_pos + CW'(1);
                                n_left   = r_fill - stop_pos - CW'(1);
                                n_state  = skt_pkg::ST_SHIFT;
                            end else begin
                                n_state = skt_pkg::ST_RESP;
                            end
                        end
                        default: begin
                            if (hit) begin
                                n_status = skt_pkg::STAT_DONE;
                                n_pos    = stop_pos;
                                n_fpay   = rd_entry.payload;
                            end
                            n_state = skt_pkg::ST_RESP;
                        end
                    endcase
                end else begin
                    ram_re   = 1'b1;
                    ram_raddr = r_ptr[AW-1:0];
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_ptr;
                    n_ptr    = r_ptr + CW'(1);
                end
            end

            skt_pkg::ST_SHIFT: begin
                // word read last cycle lands one slot up or down
                if (r_mv_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_mv_dst[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (r_left != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_src[AW-1:0];
                    n_mv_vld  = 1'b1;
                    n_mv_dst  = r_up ? (r_src + CW'(1)) : (r_src - CW'(1));
                    n_src     = r_up ? (r_src - CW'(1)) : (r_src + CW'(1));
                    n_left    = r_left - CW'(1);
                end else begin
                    n_mv_vld = 1'b0;
                    if (!r_mv_vld) begin
                        if (r_up) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pos[AW-1:0];
                            ram_wdata = {r_key, r_pay};
                            n_fill    = r_fill + CW'(1);
                        end else begin
                            n_fill = r_fill - CW'(1);
                        end
                        n_state = skt_pkg::ST_RESP;
                    end
                end
            end

            skt_pkg::ST_RESP: begin
                if (i_res_free) begin
                    o_res_valid = 1'b1;
                    n_state     = skt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = skt_pkg::ST_IDLE;
            end
        endcase
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(skt_pkg::CAPACITY))
        else $error("fill count above capacity");

    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write hit the same entry");

    a_fill_only_at_shift_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fill != $past(r_fill))) |->
            ($past(r_state) == skt_pkg::ST_SHIFT))
        else $error("fill count moved outside a shift");

    a_search_stays_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skt_pkg::ST_SEARCH && ram_re) |-> (r_ptr < r_fill))
        else $error("search read past the last entry");

endmodule

`default_nettype wire

// ===== hdl/sorted_key_table.sv =====
// Sorted key table: holds up to skt_pkg::CAPACITY entries (16-bit key, 32-bit payload) in
// ascending key order in one memory. A word takes insert, remove or lookup and gives one
// result word. Each request scans the memory from entry 0 one entry a cycle until the first
// key not below the request key, then insert and remove move the later entries one slot a
// cycle; the memory's single read port and single write port set the pace. A full insert
// or an unused code skips the scan and goes straight to the response; the result enters
// the output register as the controller returns to idle, ready for the next word. No
// clearing pass is needed after reset.
// depends on skt_pkg and skt_ctrl
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [skt_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [skt_pkg::KEY_W-1:0]     i_key,
    input  wire logic [skt_pkg::PAY_W-1:0]     i_payload,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [skt_pkg::STAT_W-1:0]         o_status,
    output logic [skt_pkg::POS_W-1:0]          o_position,
    output logic [skt_pkg::PAY_W-1:0]          o_found_payload,
    output logic [skt_pkg::COUNT_W-1:0]        o_entry_count
);

    logic              r_out_valid;
    skt_pkg::t_result  r_out;
    logic              res_free;
    logic              res_valid;
    skt_pkg::t_result  result;

    // output register frees up in the same cycle its word is taken
    assign res_free = !r_out_valid || i_out_ready;

    skt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_payload   (i_payload),
        .i_res_free  (res_free),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_position      = r_out.position;
    assign o_found_payload = r_out.found_payload;
    assign o_entry_count   = r_out.entry_count;

endmodule

`default_nettype wire

// ===== dv/tb_sorted_key_table.sv =====
// self-checking testbench for sorted_key_table: insert, remove and lookup words checked
// against an in-bench model of the sorted table, with random stalls on both channels
// depends on skt_pkg and the sorted_key_table rtl
`timescale 1ns / 1ps

module tb_sorted_key_table;

    localparam logic [skt_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int CLK_HALF      = 10;
    localparam int IDLE_PCT      = 24;
    localparam int RANDOM_WORDS  = 600;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 40;
    localparam int QUIET_FROM    = 150;
    localparam int QUIET_TO      = 300;

    typedef struct {
        logic [skt_pkg::FUNC_W-1:0] func;
        logic [skt_pkg::KEY_W-1:0]  key;
        logic [skt_pkg::PAY_W-1:0]  payload;
    } t_request;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic [skt_pkg::FUNC_W-1:0]   i_func = '0;
    logic [skt_pkg::KEY_W-1:0]    i_key = '0;
    logic [skt_pkg::PAY_W-1:0]    i_payload = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [skt_pkg::STAT_W-1:0]   o_status;
    logic [skt_pkg::POS_W-1:0]    o_position;
    logic [skt_pkg::PAY_W-1:0]    o_found_payload;
    logic [skt_pkg::COUNT_W-1:0]  o_entry_count;

    t_request                  pending_requests[$];
    skt_pkg::t_result          expected_results[$];
    logic [skt_pkg::KEY_W-1:0] table_keys[skt_pkg::CAPACITY];
    logic [skt_pkg::PAY_W-1:0] table_payloads[skt_pkg::CAPACITY];
    int              table_fill = 0;
    int              words_taken = 0;
    int              error_count = 0;
    int              stall_cycles = 0;
    logic            quiet;

    sorted_key_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_key           (i_key),
        .i_payload       (i_payload),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_position      (o_position),
        .o_found_payload (o_found_payload),
        .o_entry_count   (o_entry_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // no idling on either side for a stretch of words
    assign quiet = (words_taken >= QUIET_FROM) && (words_taken < QUIET_TO);

    // applies one request to the table copy and returns the result word it gives
    function automatic skt_pkg::t_result apply_request(logic [skt_pkg::FUNC_W-1:0] func,
                                                       logic [skt_pkg::KEY_W-1:0] key,
                                                       logic [skt_pkg::PAY_W-1:0] payload);
        skt_pkg::t_result res;
        int slot;
        int i;
        res.status        = skt_pkg::STAT_NOT_FOUND;
        res.position      = '0;
        res.found_payload = '0;
        slot = 0;
        while (slot < table_fill && key > table_keys[slot])
            slot++;
        if (func == skt_pkg::FN_INSERT) begin
            if (table_fill >= skt_pkg::CAPACITY) begin
                res.status = skt_pkg::STAT_FULL;
            end else begin
                for (i = table_fill; i > slot; i--) begin
                    table_keys[i]     = table_keys[i-1];
                    table_payloads[i] = table_payloads[i-1];
                end
                table_keys[slot]     = key;
                table_payloads[slot] = payload;
                table_fill++;
                res.status   = skt_pkg::STAT_DONE;
                res.position = slot[skt_pkg::POS_W-1:0];
            end
        end else if (func == skt_pkg::FN_REMOVE || func == skt_pkg::FN_LOOKUP) begin
            if (slot < table_fill && table_keys[slot] == key) begin
                res.status        = skt_pkg::STAT_DONE;
                res.position      = slot[skt_pkg::POS_W-1:0];
                res.found_payload = table_payloads[slot];
                if (func == skt_pkg::FN_REMOVE) begin
                    for (i = slot; i + 1 < table_fill; i++) begin
                        table_keys[i]     = table_keys[i+1];
                        table_payloads[i] = table_payloads[i+1];
                    end
                    table_fill--;
                end
            end
        end
        res.entry_count = table_fill[skt_pkg::COUNT_W-1:0];
        return res;
    endfunction

    task automatic queue_request(logic [skt_pkg::FUNC_W-1:0] func,
                                 logic [skt_pkg::KEY_W-1:0] key,
                                 logic [skt_pkg::PAY_W-1:0] payload);
        t_request req;
        req.func    = func;
        req.key     = key;
        req.payload = payload;
        pending_requests.push_back(req);
    endtask

    task automatic check_field(string name, logic [skt_pkg::PAY_W-1:0] want,
                               logic [skt_pkg::PAY_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // driver: presents the next pending word, valid held until taken
    always @(posedge i_clk) begin
        t_request req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(apply_request(i_func, i_key, i_payload));
                words_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_requests.size() > 0
                        && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    req = pending_requests.pop_front();
                    i_in_valid <= 1'b1;
                    i_func     <= req.func;
                    i_key      <= req.key;
                    i_payload  <= req.payload;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word against the oldest expectation
    always @(posedge i_clk) begin
        skt_pkg::t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result word, status %0h position %0h",
                             $time, o_status, o_position);
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", skt_pkg::PAY_W'(want.status),
                                skt_pkg::PAY_W'(o_status));
                    check_field("position", skt_pkg::PAY_W'(want.position),
                                skt_pkg::PAY_W'(o_position));
                    check_field("found_payload", want.found_payload, o_found_payload);
                    check_field("entry_count", skt_pkg::PAY_W'(want.entry_count),
                                skt_pkg::PAY_W'(o_entry_count));
                end
            end
            i_out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [skt_pkg::KEY_W-1:0] key_pool[8];
        logic [skt_pkg::KEY_W-1:0] key;
        logic [skt_pkg::FUNC_W-1:0] func;
        int random_count;
        int seg_len;
        int mix;
        int pick;
        int n;

        // directed: empty table, unused code, key extremes, duplicate keys
        queue_request(skt_pkg::FN_LOOKUP, 16'h1234, 32'h0);
        queue_request(skt_pkg::FN_REMOVE, 16'h0000, 32'h0);
        queue_request(FUNC_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        queue_request(skt_pkg::FN_INSERT, 16'h0000, 32'hFFFF_FFFF);
        queue_request(skt_pkg::FN_INSERT, 16'hFFFF, 32'h0000_0000);
        queue_request(skt_pkg::FN_INSERT, 16'h8000, 32'hAAAA_AAAA);
        queue_request(skt_pkg::FN_INSERT, 16'h8000, 32'h5555_5555);
        queue_request(skt_pkg::FN_INSERT, 16'h8000, 32'h1234_5678);
        queue_request(skt_pkg::FN_LOOKUP, 16'h8000, 32'h0);
        queue_request(skt_pkg::FN_REMOVE, 16'h8000, 32'h0);
        queue_request(skt_pkg::FN_LOOKUP, 16'h8000, 32'h0);
        queue_request(skt_pkg::FN_LOOKUP, 16'hFFFF, 32'h0);
        queue_request(skt_pkg::FN_LOOKUP, 16'h7FFF, 32'h0);
        queue_request(FUNC_UNUSED, 16'h8000, 32'h0);
        queue_request(skt_pkg::FN_REMOVE, 16'h0000, 32'h0);
        queue_request(skt_pkg::FN_LOOKUP, 16'h0000, 32'h0);
        queue_request(skt_pkg::FN_REMOVE, 16'hFFFF, 32'h0);
        queue_request(skt_pkg::FN_REMOVE, 16'h8000, 32'h0);
        queue_request(skt_pkg::FN_REMOVE, 16'h8000, 32'h0);
        queue_request(skt_pkg::FN_LOOKUP, 16'h8000, 32'h0);

        // random: segments that lean toward filling, draining or a mix, keys from a
        // small pool so that matches and duplicates are common
        random_count = 0;
        while (random_count < RANDOM_WORDS) begin
            mix = $urandom_range(2);
            seg_len = $urandom_range(20, 60);
            for (n = 0; n < 8; n++)
                key_pool[n] = skt_pkg::KEY_W'($urandom_range(16'hFFFF));
            for (n = 0; n < seg_len; n++) begin
                pick = $urandom_range(99);
                if (pick < 8)
                    key = 16'h0000;
                else if (pick < 16)
                    key = 16'hFFFF;
                else if (pick < 85)
                    key = key_pool[$urandom_range(7)];
                else
                    key = skt_pkg::KEY_W'($urandom_range(16'hFFFF));
                pick = $urandom_range(99);
                if (pick < 3)
                    func = FUNC_UNUSED;
                else if (pick < (mix == 0 ? 70 : mix == 1 ? 15 : 40))
                    func = skt_pkg::FN_INSERT;
                else if (pick < (mix == 0 ? 85 : mix == 1 ? 75 : 70))
                    func = skt_pkg::FN_REMOVE;
                else
                    func = skt_pkg::FN_LOOKUP;
                queue_request(func, key, $urandom);
                random_count++;
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
